// ===== hw/rtl/epft_pkg.sv =====
// Package for the envelope period and fall time block: transaction types and constants.
package epft_pkg;

  localparam int unsigned PeriodWidthDef = 32;

  // One input transaction.
  typedef struct packed {
    logic [7:0]  divide_knob;
    logic [31:0] clock_period;
    logic [7:0]  skew;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic signed [4:0] divide_amount;
    logic [31:0]       divided_period;
    logic [31:0]       fall_time;
    logic              period_saturated;
  } out_t;

  // Register byte addresses.
  localparam logic [2:0] AddrLimitSkewEnable = 3'h0;
  localparam logic [2:0] AddrLimitSkewTime   = 3'h4;

  // Reciprocals for constant division: floor(2^s / k), s = 33 for 3, 34 for 5 and 7.
  localparam logic [31:0] Recip3 = 32'hAAAA_AAAA;
  localparam logic [31:0] Recip5 = 32'hCCCC_CCCC;
  localparam logic [31:0] Recip7 = 32'h9249_2492;

  // Fall time constants.
  localparam logic [31:0] FallSkew0  = 32'd768;
  localparam logic [31:0] FallSkew1  = 32'd1024;
  localparam logic [31:0] FallSkew2  = 32'd1280;
  localparam logic [31:0] FallFloor  = 32'd1280;
  localparam logic [16:0] FallSqBase = 17'd960;
  localparam logic [31:0] FallMargin = 32'd256;
  localparam logic [7:0]  SkewTop    = 8'd220;
  localparam logic [7:0]  SkewRevLo  = 8'd200;
  localparam logic [7:0]  SkewHalfLo = 8'd101;
  localparam logic [7:0]  SkewHalfHi = 8'd114;
  localparam logic [7:0]  SkewSqHi   = 8'd25;

endpackage

// ===== hw/rtl/envelope_period_and_fall_time.sv =====
// Envelope period and fall time: knob ladder, period scaling and fall time, five-stage pipeline.

// One transaction enters per clock while the output is not stalled and passes through the
// five register stages: ladder decode, reciprocal and scaling multiply, quotient correction
// and saturation, fall-time multiply, and final fall-time selection into the output register.
// Each stage holds its own valid bit, so a stalled output only holds back stages that are full
// and bubbles still close up. The knob picks an amount of 8..2 (period multiplied, saturating
// at all ones in PERIOD_WIDTH bits with period_saturated set), 1 (period passed through) or
// -2..-8 (period divided by the magnitude, rounded down). Bits of clock_period above
// PERIOD_WIDTH are ignored. The fall time follows the skew by piecewise rules; with
// limit_skew_enable set and divided_period at least half the skew limit time the
// limited-skew rules apply instead. Underflowing subtractions clamp at zero. Registers sit on
// the APB port at byte 0 (limit_skew_enable) and byte 4 (skew limit time), decoded on
// paddr[2]; they are to be written only while no transaction is in flight.
module envelope_period_and_fall_time #(
  parameter int unsigned PERIOD_WIDTH = epft_pkg::PeriodWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input channel
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  epft_pkg::in_t   in_data_i,
  // output channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output epft_pkg::out_t  out_data_o,
  // configuration port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import epft_pkg::*;

  localparam logic [PERIOD_WIDTH-1:0] PeriodMax = {PERIOD_WIDTH{1'b1}};

  // scaling modes
  localparam logic [1:0] ScPass  = 2'd0;
  localparam logic [1:0] ScMul   = 2'd1;
  localparam logic [1:0] ScShift = 2'd2;
  localparam logic [1:0] ScRecip = 2'd3;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        lsk_en_q;
  logic [31:0] lsk_time_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsk_en_q   <= 1'b0;
      lsk_time_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        lsk_time_q <= pwdata;
      end else begin
        lsk_en_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = lsk_time_q;
    end else begin
      prdata = {31'b0, lsk_en_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: a stage loads when it is empty or the next one loads
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: knob ladder, scaling mode, dividend and reciprocal
  // ---------------------------------------------------------------------------
  logic signed [4:0]       amount_d;
  logic [3:0]              mag_d;
  logic [PERIOD_WIDTH-1:0] period_d;
  logic [PERIOD_WIDTH-1:0] x_d;
  logic [1:0]              mode_d;
  logic [31:0]             recip_d;
  logic [3:0]              k_d;
  logic                    s33_d;

  always_comb begin
    logic [7:0] k;
    k = in_data_i.divide_knob;
    if      (k <= 8'd1)   amount_d = 5'sd8;
    else if (k <= 8'd10)  amount_d = 5'sd7;
    else if (k <= 8'd26)  amount_d = 5'sd6;
    else if (k <= 8'd46)  amount_d = 5'sd5;
    else if (k <= 8'd65)  amount_d = 5'sd4;
    else if (k <= 8'd85)  amount_d = 5'sd3;
    else if (k <= 8'd100) amount_d = 5'sd2;
    else if (k <= 8'd118) amount_d = 5'sd1;
    else if (k <= 8'd128) amount_d = -5'sd2;
    else if (k <= 8'd150) amount_d = -5'sd3;
    else if (k <= 8'd170) amount_d = -5'sd4;
    else if (k <= 8'd188) amount_d = -5'sd5;
    else if (k <= 8'd207) amount_d = -5'sd6;
    else if (k <= 8'd220) amount_d = -5'sd7;
    else                  amount_d = -5'sd8;
  end

  always_comb begin
    logic [4:0] neg;
    neg      = 5'(-amount_d);
    mag_d    = amount_d[4] ? neg[3:0] : amount_d[3:0];
    period_d = in_data_i.clock_period[PERIOD_WIDTH-1:0];
    x_d      = period_d;
    recip_d  = Recip3;
    k_d      = 4'd3;
    s33_d    = 1'b1;
    if (!amount_d[4]) begin
      mode_d = (mag_d == 4'd1) ? ScPass : ScMul;
    end else begin
      case (mag_d)
        4'd2, 4'd4, 4'd8: mode_d = ScShift;
        4'd3: begin
          mode_d = ScRecip;
        end
        4'd5: begin
          mode_d  = ScRecip;
          recip_d = Recip5;
          k_d     = 4'd5;
          s33_d   = 1'b0;
        end
        4'd6: begin
          // floor(x/6) = floor(floor(x/2)/3)
          mode_d = ScRecip;
          x_d    = period_d >> 1;
        end
        4'd7: begin
          mode_d  = ScRecip;
          recip_d = Recip7;
          k_d     = 4'd7;
          s33_d   = 1'b0;
        end
        default: mode_d = ScPass;
      endcase
    end
  end

  logic signed [4:0]       s1_amount_q;
  logic [3:0]              s1_mag_q;
  logic [PERIOD_WIDTH-1:0] s1_period_q;
  logic [PERIOD_WIDTH-1:0] s1_x_q;
  logic [1:0]              s1_mode_q;
  logic [31:0]             s1_recip_q;
  logic [3:0]              s1_k_q;
  logic                    s1_s33_q;
  logic [7:0]              s1_skew_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_amount_q <= amount_d;
      s1_mag_q    <= mag_d;
      s1_period_q <= period_d;
      s1_x_q      <= x_d;
      s1_mode_q   <= mode_d;
      s1_recip_q  <= recip_d;
      s1_k_q      <= k_d;
      s1_s33_q    <= s33_d;
      s1_skew_q   <= in_data_i.skew;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: reciprocal product and scaling product
  // ---------------------------------------------------------------------------
  logic [63:0]             s2_rprod_q;
  logic [PERIOD_WIDTH+3:0] s2_mprod_q;
  logic signed [4:0]       s2_amount_q;
  logic [3:0]              s2_mag_q;
  logic [PERIOD_WIDTH-1:0] s2_period_q;
  logic [PERIOD_WIDTH-1:0] s2_x_q;
  logic [1:0]              s2_mode_q;
  logic [3:0]              s2_k_q;
  logic                    s2_s33_q;
  logic [7:0]              s2_skew_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_rprod_q  <= 64'(s1_x_q) * 64'(s1_recip_q);
      s2_mprod_q  <= (PERIOD_WIDTH+4)'(s1_period_q) * (PERIOD_WIDTH+4)'(s1_mag_q);
      s2_amount_q <= s1_amount_q;
      s2_mag_q    <= s1_mag_q;
      s2_period_q <= s1_period_q;
      s2_x_q      <= s1_x_q;
      s2_mode_q   <= s1_mode_q;
      s2_k_q      <= s1_k_q;
      s2_s33_q    <= s1_s33_q;
      s2_skew_q   <= s1_skew_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: quotient correction, saturation, period select
  // ---------------------------------------------------------------------------
  logic [PERIOD_WIDTH-1:0] d_d;
  logic                    sat_d;

  always_comb begin
    logic [31:0] q_est;
    logic [35:0] kq;
    logic [31:0] r;
    logic [31:0] q;
    q_est = s2_s33_q ? {1'b0, s2_rprod_q[63:33]} : {2'b0, s2_rprod_q[63:34]};
    kq    = 36'(q_est) * 36'(s2_k_q);
    // estimate is low by at most one
    r     = 32'(s2_x_q) - kq[31:0];
    q     = (r >= 32'(s2_k_q)) ? q_est + 32'd1 : q_est;
    sat_d = 1'b0;
    case (s2_mode_q)
      ScMul: begin
        if (|s2_mprod_q[PERIOD_WIDTH+3:PERIOD_WIDTH]) begin
          d_d   = PeriodMax;
          sat_d = 1'b1;
        end else begin
          d_d = s2_mprod_q[PERIOD_WIDTH-1:0];
        end
      end
      ScShift: begin
        case (s2_mag_q)
          4'd2:    d_d = s2_period_q >> 1;
          4'd4:    d_d = s2_period_q >> 2;
          default: d_d = s2_period_q >> 3;
        endcase
      end
      ScRecip: d_d = q[PERIOD_WIDTH-1:0];
      default: d_d = s2_period_q;
    endcase
  end

  logic [PERIOD_WIDTH-1:0] s3_d_q;
  logic                    s3_sat_q;
  logic signed [4:0]       s3_amount_q;
  logic [7:0]              s3_skew_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_d_q      <= d_d;
      s3_sat_q    <= sat_d;
      s3_amount_q <= s2_amount_q;
      s3_skew_q   <= s2_skew_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: skew product, clamped margins and squared terms
  // ---------------------------------------------------------------------------
  logic [31:0] d32;
  logic [31:0] prod_d;
  logic [31:0] lim256_d;
  logic [31:0] liml_d;
  logic [16:0] squ_d;
  logic [17:0] rsq_d;
  logic [31:0] dmu_d;
  logic        lsk_d;

  always_comb begin
    logic [9:0]  sk_sq;
    logic [7:0]  rev;
    logic [11:0] rv_sq;
    d32      = 32'(s3_d_q);
    prod_d   = 32'(s3_skew_q) * 32'(d32[31:8]);
    lim256_d = (d32 > FallMargin) ? d32 - FallMargin : '0;
    liml_d   = (d32 > lsk_time_q) ? d32 - lsk_time_q : '0;
    // only used for skew up to 25, which fits in five bits
    sk_sq    = 10'(s3_skew_q[4:0]) * 10'(s3_skew_q[4:0]);
    squ_d    = 17'({sk_sq, 6'b0}) + FallSqBase;
    // reverse skew only used above 200, so it fits in six bits
    rev      = 8'd255 - s3_skew_q;
    rv_sq    = 12'(rev[5:0]) * 12'(rev[5:0]);
    rsq_d    = {rv_sq, 6'b0};
    dmu_d    = d32 - 32'(rsq_d);
    lsk_d    = lsk_en_q && !(d32 < (lsk_time_q >> 1));
  end

  logic [31:0]       s4_prod_q;
  logic [31:0]       s4_lim256_q;
  logic [31:0]       s4_liml_q;
  logic [16:0]       s4_squ_q;
  logic [17:0]       s4_rsq_q;
  logic [31:0]       s4_dmu_q;
  logic              s4_lsk_q;
  logic [31:0]       s4_d_q;
  logic              s4_sat_q;
  logic signed [4:0] s4_amount_q;
  logic [7:0]        s4_skew_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_prod_q   <= prod_d;
      s4_lim256_q <= lim256_d;
      s4_liml_q   <= liml_d;
      s4_squ_q    <= squ_d;
      s4_rsq_q    <= rsq_d;
      s4_dmu_q    <= dmu_d;
      s4_lsk_q    <= lsk_d;
      s4_d_q      <= d32;
      s4_sat_q    <= s3_sat_q;
      s4_amount_q <= s3_amount_q;
      s4_skew_q   <= s3_skew_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: fall time selection into the output register
  // ---------------------------------------------------------------------------
  logic [31:0] fall_d;

  always_comb begin
    logic [31:0] t;
    logic [31:0] u;
    logic        half;
    half = (s4_skew_q > SkewHalfLo) && (s4_skew_q <= SkewHalfHi);
    t    = s4_prod_q;
    u    = 32'(s4_squ_q);
    if (!s4_lsk_q) begin
      if (s4_skew_q == 8'd0) begin
        fall_d = FallSkew0;
      end else if (s4_skew_q == 8'd1) begin
        fall_d = FallSkew1;
      end else if (s4_skew_q == 8'd2) begin
        fall_d = FallSkew2;
      end else if (s4_skew_q <= SkewSqHi) begin
        t      = (s4_prod_q < FallFloor) ? FallFloor : s4_prod_q;
        fall_d = (t < u) ? t : u;
      end else if (s4_skew_q >= SkewTop) begin
        fall_d = s4_lim256_q;
      end else if (s4_skew_q > SkewRevLo) begin
        t = (s4_prod_q > s4_lim256_q) ? s4_lim256_q : s4_prod_q;
        if (32'(s4_rsq_q) > s4_lim256_q) begin
          fall_d = t;
        end else begin
          fall_d = (t > s4_dmu_q) ? t : s4_dmu_q;
        end
      end else if (half) begin
        fall_d = s4_d_q >> 1;
      end else begin
        fall_d = s4_prod_q;
      end
    end else begin
      // limited-skew rules: half the period in the half band, else clamp between the limit time and the end margin
      if (half) begin
        fall_d = s4_d_q >> 1;
      end else begin
        t      = (s4_prod_q < lsk_time_q) ? lsk_time_q : s4_prod_q;
        fall_d = (t > s4_liml_q) ? s4_liml_q : t;
      end
    end
  end

  out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out_q.divide_amount    <= s4_amount_q;
      out_q.divided_period   <= s4_d_q;
      out_q.fall_time        <= fall_d;
      out_q.period_saturated <= s4_sat_q;
    end
  end

  assign out_data_o = out_q;

endmodule
